// ===== sv/sawc_pkg.sv =====
package sawc_pkg;

  // row geometry
  localparam int NUM_SLOTS = 16;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int CNT_W     = SLOT_W + 1;
  localparam int SUM_W     = ((CNT_W > 5) ? CNT_W : 5) + 1;

  // port field widths
  localparam int MODE_W   = 2;
  localparam int AMOUNT_W = 5;
  localparam int ID_W     = 4;
  localparam int TOP_W    = 5;
  localparam int OCC_W    = 16;

  // command codes
  localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COMPACT = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NONE    = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_ALLOC,
    S_FREE,
    S_COMPACT,
    S_REPORT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic alloc_init;
    logic set_fail;
    logic alloc_step;
    logic free_step;
    logic compact_step;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              amount_zero;
    logic              no_room;
    logic              scan_done;
  } dp_status_t;

endpackage

// ===== sv/sawc_ctrl.sv =====
module sawc_ctrl import sawc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  dp_status_t dp_status,
  output ctrl_cmd_t  cmd,
  output logic       busy,
  output logic       report
);

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        unique case (dp_status.mode)
          MODE_ALLOC: begin
            if (dp_status.amount_zero || dp_status.no_room) state_nxt = S_REPORT;
            else state_nxt = S_ALLOC;
          end
          MODE_FREE:    state_nxt = S_FREE;
          MODE_COMPACT: state_nxt = S_COMPACT;
          default:      state_nxt = S_REPORT;
        endcase
      end
      S_ALLOC, S_FREE, S_COMPACT: begin
        if (dp_status.scan_done) state_nxt = S_REPORT;
      end
      S_REPORT: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd = '0;
    busy = (state_r != S_IDLE);
    report = (state_r == S_REPORT);
    unique case (state_r)
      S_IDLE: cmd.capture = start;
      S_DECODE: begin
        if (dp_status.mode == MODE_ALLOC && !dp_status.amount_zero) begin
          cmd.set_fail   = dp_status.no_room;
          cmd.alloc_init = !dp_status.no_room;
        end
      end
      S_ALLOC:   cmd.alloc_step = 1'b1;
      S_FREE:    cmd.free_step = 1'b1;
      S_COMPACT: cmd.compact_step = 1'b1;
      default: ;
    endcase
  end

endmodule

// ===== sv/sawc_dp.sv =====
module sawc_dp import sawc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  ctrl_cmd_t           cmd,
  input  logic [MODE_W-1:0]   in_mode,
  input  logic [AMOUNT_W-1:0] in_amount,
  input  logic [ID_W-1:0]     in_slot_id,
  output dp_status_t          dp_status,
  output logic                status,
  output logic [TOP_W-1:0]    top_index,
  output logic [OCC_W-1:0]    occupancy
);

  // control state
  logic [NUM_SLOTS-1:0] used_r, used_nxt;
  logic [CNT_W-1:0]     top_r, top_nxt;
  logic                 status_r;
  logic [SLOT_W-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0]     dst_r, dst_nxt;

  // captured transaction and block bounds
  logic [MODE_W-1:0]    mode_r;
  logic [AMOUNT_W-1:0]  amount_r;
  logic [ID_W-1:0]      id_r;
  logic [SLOT_W-1:0]    start_r;
  logic [SLOT_W-1:0]    last_r;

  // per slot block bounds, only read for used slots
  logic [SLOT_W-1:0]    first_mem_r [NUM_SLOTS];
  logic [SLOT_W-1:0]    last_mem_r  [NUM_SLOTS];

  logic [CNT_W-1:0]     alloc_start;
  logic [SUM_W-1:0]     alloc_end;
  logic [SLOT_W-1:0]    cur_first;
  logic [SLOT_W-1:0]    cur_last;
  logic                 cur_used;
  logic                 covers;
  logic [SLOT_W-1:0]    shift;
  logic [SLOT_W-1:0]    moved_first;
  logic [SLOT_W-1:0]    moved_last;
  logic [SLOT_W-1:0]    dst_idx;
  logic                 at_end;

  // room check on the run above top
  assign alloc_start = top_r + CNT_W'(1);
  assign alloc_end   = SUM_W'(alloc_start) + SUM_W'(amount_r);

  assign dp_status.mode        = mode_r;
  assign dp_status.amount_zero = (amount_r == '0);
  assign dp_status.no_room     = (alloc_end > SUM_W'(NUM_SLOTS));
  assign at_end                = (idx_r == SLOT_W'(NUM_SLOTS - 1));
  assign dp_status.scan_done   = (mode_r == MODE_ALLOC) ? (idx_r == last_r) : at_end;

  // current slot view
  assign cur_used  = used_r[idx_r];
  assign cur_first = first_mem_r[idx_r];
  assign cur_last  = last_mem_r[idx_r];
  assign covers    = cur_used && ((ID_W + SLOT_W)'(cur_first) <= (ID_W + SLOT_W)'(id_r))
                     && ((ID_W + SLOT_W)'(cur_last) >= (ID_W + SLOT_W)'(id_r));

  // compaction move distance and shifted bounds
  assign dst_idx     = dst_r[SLOT_W-1:0];
  assign shift       = idx_r - dst_idx;
  assign moved_first = (cur_first >= shift) ? cur_first - shift : '0;
  assign moved_last  = (cur_last >= shift) ? cur_last - shift : '0;

  // next values of control state
  always_comb begin
    used_nxt = used_r;
    top_nxt  = top_r;
    idx_nxt  = idx_r;
    dst_nxt  = dst_r;
    if (cmd.capture) begin
      idx_nxt = '0;
      dst_nxt = '0;
    end
    if (cmd.alloc_init) begin
      idx_nxt = alloc_start[SLOT_W-1:0];
    end
    if (cmd.alloc_step) begin
      used_nxt[idx_r] = 1'b1;
      idx_nxt = idx_r + SLOT_W'(1);
      if (idx_r == last_r) top_nxt = CNT_W'(last_r);
    end
    if (cmd.free_step) begin
      if (covers) used_nxt[idx_r] = 1'b0;
      idx_nxt = idx_r + SLOT_W'(1);
    end
    if (cmd.compact_step) begin
      if (cur_used) begin
        used_nxt[idx_r]   = 1'b0;
        used_nxt[dst_idx] = 1'b1;
        dst_nxt = dst_r + CNT_W'(1);
      end
      idx_nxt = idx_r + SLOT_W'(1);
      if (at_end) top_nxt = dst_nxt - CNT_W'(1);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r   <= '0;
      top_r    <= '1;
      status_r <= 1'b0;
      idx_r    <= '0;
      dst_r    <= '0;
    end else begin
      used_r <= used_nxt;
      top_r  <= top_nxt;
      idx_r  <= idx_nxt;
      dst_r  <= dst_nxt;
      if (cmd.capture) status_r <= 1'b0;
      else if (cmd.set_fail) status_r <= 1'b1;
    end
  end

  // transaction capture and run bounds
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r   <= in_mode;
      amount_r <= in_amount;
      id_r     <= in_slot_id;
    end
    if (cmd.alloc_init) begin
      start_r <= alloc_start[SLOT_W-1:0];
      last_r  <= alloc_end[SLOT_W-1:0] - SLOT_W'(1);
    end
  end

  // block bound store writes
  always_ff @(posedge clk) begin
    if (cmd.alloc_step) begin
      first_mem_r[idx_r] <= start_r;
      last_mem_r[idx_r]  <= last_r;
    end else if (cmd.compact_step && cur_used) begin
      first_mem_r[dst_idx] <= moved_first;
      last_mem_r[dst_idx]  <= moved_last;
    end
  end

  // result fields
  assign status    = status_r;
  assign top_index = TOP_W'(signed'(top_r));
  assign occupancy = OCC_W'(used_r);

endmodule

// ===== sv/slot_allocator_with_compaction_top.sv =====
// Slot allocator with compaction. A command is taken at a rising edge where
// start is high and busy is low; busy then stays high until the result has been
// shown. The result is on out_status, out_top_index and out_occupancy for
// exactly one cycle, marked by out_valid, and cannot be held off by the
// receiver, so it must be captured in that cycle. After a decode state the
// datapath walks one slot per cycle: over the n slots of an allocation of n
// slots, and over all NUM_SLOTS slots for free and compact; a zero amount, a
// refused allocation or the unused mode goes from decode straight to the
// result. busy drops in the cycle right after out_valid, so the next
// command can be taken at the end of that cycle.
module slot_allocator_with_compaction_top import sawc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [MODE_W-1:0]   in_mode,
  input  logic [AMOUNT_W-1:0] in_amount,
  input  logic [ID_W-1:0]     in_slot_id,
  output logic                out_valid,
  output logic                out_status,
  output logic [TOP_W-1:0]    out_top_index,
  output logic [OCC_W-1:0]    out_occupancy
);

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  // sequencer
  sawc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .dp_status (dp_status),
    .cmd       (cmd),
    .busy      (busy),
    .report    (out_valid)
  );

  // slot row and block bounds
  sawc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_mode    (in_mode),
    .in_amount  (in_amount),
    .in_slot_id (in_slot_id),
    .dp_status  (dp_status),
    .status     (out_status),
    .top_index  (out_top_index),
    .occupancy  (out_occupancy)
  );

endmodule
